/* src/dsu_pkg.sv */
// ============================================================================
// dsu_pkg
// Shared constants and types for the decimal size parser: character codes,
// unit codes and the result record passed from the parser core to the top.
// ============================================================================
package dsu_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int OUT_BITS       = 64;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_K     = 8'h6B;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_G     = 8'h67;
    localparam logic [7:0] CHAR_CARET = 8'h5E;

    typedef logic [2:0] t_unit;

    localparam t_unit UNIT_B    = 3'd0;
    localparam t_unit UNIT_K    = 3'd1;
    localparam t_unit UNIT_M    = 3'd2;
    localparam t_unit UNIT_G    = 3'd3;
    localparam t_unit UNIT_POW  = 3'd4;
    localparam t_unit UNIT_BAD  = 3'd5;
    localparam t_unit UNIT_NONE = 3'd7;

    localparam logic MODE_SIZE = 1'b0;
    localparam logic MODE_INT  = 1'b1;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                error;
    } t_result;

    function automatic t_unit unit_of_char(input logic [7:0] c);
        t_unit u;
        begin
            case (c)
                CHAR_B:     u = UNIT_B;
                CHAR_K:     u = UNIT_K;
                CHAR_M:     u = UNIT_M;
                CHAR_G:     u = UNIT_G;
                CHAR_CARET: u = UNIT_POW;
                default:    u = UNIT_BAD;
            endcase
            return u;
        end
    endfunction

endpackage

/* src/dsu_core.sv */
// ============================================================================
// dsu_core
// Per-string parse state. Steps once per character and forms the result
// from the current state when the terminating NUL is presented.
// ============================================================================
module dsu_core #(
    parameter int VALUE_BITS = dsu_pkg::VALUE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_char_code,
    input  logic [2:0]       i_default_unit,
    input  logic             i_number_mode,
    output dsu_pkg::t_result o_result
);
    import dsu_pkg::*;

    localparam int SH_BITS = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {
        PH_START,
        PH_EQ,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    logic [VALUE_BITS-1:0] r_acc;
    logic [VALUE_BITS-1:0] n_acc;
    t_phase                r_phase;
    t_phase                n_phase;
    logic                  r_seen;
    logic                  n_seen;
    t_unit                 r_unit;
    t_unit                 n_unit;

    logic                  is_digit;
    logic [VALUE_BITS-1:0] acc_x10;
    t_unit                 use_unit;
    logic [VALUE_BITS-1:0] val;
    logic                  err;

    assign is_digit = (i_char_code >= CHAR_0) && (i_char_code <= CHAR_9);
    assign acc_x10  = (r_acc << 3) + (r_acc << 1) + VALUE_BITS'(i_char_code[3:0]);

    always_comb begin
        n_acc   = r_acc;
        n_phase = r_phase;
        n_seen  = r_seen;
        n_unit  = r_unit;
        if (i_char_code == CHAR_NUL) begin
            n_acc   = '0;
            n_phase = PH_START;
            n_seen  = 1'b0;
            n_unit  = UNIT_NONE;
        end else if (r_phase != PH_STOP) begin
            if (is_digit) begin
                n_acc   = acc_x10;
                n_seen  = 1'b1;
                n_phase = PH_DIGITS;
            end else if (r_phase == PH_START && i_char_code == CHAR_EQ) begin
                n_phase = PH_EQ;
            end else begin
                if (r_phase == PH_DIGITS) begin
                    n_unit = unit_of_char(i_char_code);
                end
                n_phase = PH_STOP;
            end
        end
    end

    assign use_unit = (r_phase == PH_DIGITS) ? t_unit'(i_default_unit) : r_unit;

    always_comb begin
        val = '0;
        err = 1'b0;
        if (i_number_mode == MODE_INT) begin
            val = r_acc;
            err = (r_phase != PH_DIGITS);
        end else if (!r_seen) begin
            err = 1'b1;
        end else begin
            case (use_unit)
                UNIT_B:   val = r_acc;
                UNIT_K:   val = r_acc << 10;
                UNIT_M:   val = r_acc << 20;
                UNIT_G:   val = r_acc << 30;
                UNIT_POW: begin
                    if (r_acc < VALUE_BITS'(VALUE_BITS)) begin
                        val = VALUE_BITS'(1) << r_acc[SH_BITS-1:0];
                    end
                end
                default:  err = 1'b1;
            endcase
        end
    end

    assign o_result.value = OUT_BITS'(val);
    assign o_result.error = err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_phase <= PH_START;
            r_seen  <= 1'b0;
            r_unit  <= UNIT_NONE;
        end else if (i_step) begin
            r_acc   <= n_acc;
            r_phase <= n_phase;
            r_seen  <= n_seen;
            r_unit  <= n_unit;
        end
    end

endmodule

/* src/decimal_size_with_unit_parser.sv */
// ============================================================================
// decimal_size_with_unit_parser
// Parses a decimal string, one character per transfer, into a number with an
// optional unit suffix (b, k, m, g or power of two) or into a plain integer.
// The block takes one character every clock while o_stall is low. A character
// is held in an input register and applied to the parse state when the core
// steps; when it is the NUL terminator the result is loaded into the output
// register in that same cycle and offered from there. The input side stalls
// only when a NUL waits for an output register that is still held by a
// stalled result. The number mode register is sampled when the NUL is
// applied.
// ============================================================================
module decimal_size_with_unit_parser #(
    parameter int VALUE_BITS = dsu_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_char_code,
    input  logic [2:0]                   i_default_unit,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [dsu_pkg::OUT_BITS-1:0] o_parsed_value,
    output logic                         o_error_flag
);
    import dsu_pkg::*;

    logic       r_mode;
    logic       r_in_valid;
    logic [7:0] r_char;
    logic [2:0] r_dflt;
    logic       r_out_valid;
    t_result    r_out;

    logic       in_is_nul;
    logic       step;
    t_result    core_result;

    assign in_is_nul = (r_char == CHAR_NUL);
    assign step      = r_in_valid && (!in_is_nul || !r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !step;

    dsu_core #(
        .VALUE_BITS(VALUE_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_char_code    (r_char),
        .i_default_unit (r_dflt),
        .i_number_mode  (r_mode),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SIZE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_char <= i_char_code;
            r_dflt <= i_default_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && in_is_nul) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (step && in_is_nul) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_parsed_value = r_out.value;
    assign o_error_flag   = r_out.error;

endmodule

/* src/dsu_checker.sv */
// ============================================================================
// dsu_checker
// Port-level checks for the decimal size parser, bound to the top level.
// ============================================================================
module dsu_checker #(
    parameter int VALUE_BITS = dsu_pkg::VALUE_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [7:0]                   i_char_code,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [dsu_pkg::OUT_BITS-1:0] o_parsed_value,
    input logic                         o_error_flag
);
    import dsu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_parsed_value) && $stable(o_error_flag))
        else $error("Stalled result changed or was dropped.");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_parsed_value >> VALUE_BITS) == '0)
        else $error("Result exceeds the value width.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_char_code == CHAR_NUL, 2))
        else $error("Result appeared without a terminator transfer.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled while the output side was free.");

endmodule

bind decimal_size_with_unit_parser dsu_checker #(
    .VALUE_BITS(VALUE_BITS)
) u_dsu_checker (.*);

/* tb/tb_decimal_size_with_unit_parser.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_decimal_size_with_unit_parser
// Self-checking testbench for the decimal size parser. A driver sends strings
// one character per transfer from a queue, a predictor tracks the parse state
// of every accepted character, and a monitor compares each result transfer
// with the oldest predicted result. Both sides idle at random, the receiver
// holds off once for a long stretch, and the number mode is changed between
// phases of directed and random strings.
// ============================================================================
module tb_decimal_size_with_unit_parser;
    import dsu_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_CHARS = 500;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_EQ     = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    localparam logic [7:0] UNIT_CHARS [5] = '{CHAR_B, CHAR_K, CHAR_M, CHAR_G, CHAR_CARET};

    typedef struct {
        logic [7:0] code;
        logic [2:0] dflt;
    } t_char_item;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_data = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [7:0]          i_char_code = 8'd0;
    logic [2:0]          i_default_unit = 3'd0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [OUT_BITS-1:0] o_parsed_value;
    logic                o_error_flag;

    t_char_item char_queue[$];
    t_result    parsed_results[$];

    logic [63:0] acc_value = '0;
    logic [1:0]  parse_state = PH_START;
    logic        digit_seen = 1'b0;
    t_unit       unit_sel = UNIT_NONE;
    logic        int_mode = MODE_SIZE;

    logic       in_fire = 1'b0;
    int         send_idle = 0;
    int         send_burst = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    int         error_count = 0;
    int         cycle_count = 0;
    int         chars_pushed = 0;
    t_char_item send_item;

    decimal_size_with_unit_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_default_unit (i_default_unit),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_parsed_value (o_parsed_value),
        .o_error_flag   (o_error_flag)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        if (r < 99) return $urandom_range(7, 15);
        return $urandom_range(30, 60);
    endfunction

    task automatic parse_char(input logic [7:0] code, input logic [2:0] dflt);
        t_result res;
        t_unit   u;
        if (code != CHAR_NUL) begin
            if (parse_state == PH_STOP) return;
            if (code >= CHAR_0 && code <= CHAR_9) begin
                acc_value   = acc_value * 64'd10 + 64'(code - CHAR_0);
                digit_seen  = 1'b1;
                parse_state = PH_DIGITS;
            end else if (parse_state == PH_START && code == CHAR_EQ) begin
                parse_state = PH_EQ;
            end else begin
                if (parse_state == PH_DIGITS) begin
                    case (code)
                        CHAR_B:     unit_sel = UNIT_B;
                        CHAR_K:     unit_sel = UNIT_K;
                        CHAR_M:     unit_sel = UNIT_M;
                        CHAR_G:     unit_sel = UNIT_G;
                        CHAR_CARET: unit_sel = UNIT_POW;
                        default:    unit_sel = UNIT_BAD;
                    endcase
                end
                parse_state = PH_STOP;
            end
            return;
        end
        res.value = '0;
        res.error = 1'b0;
        if (int_mode == MODE_INT) begin
            res.value = acc_value;
            res.error = parse_state != PH_DIGITS;
        end else if (!digit_seen) begin
            res.error = 1'b1;
        end else begin
            u = (parse_state == PH_DIGITS) ? t_unit'(dflt) : unit_sel;
            case (u)
                UNIT_B:   res.value = acc_value;
                UNIT_K:   res.value = acc_value << 10;
                UNIT_M:   res.value = acc_value << 20;
                UNIT_G:   res.value = acc_value << 30;
                UNIT_POW: res.value = (acc_value < 64) ? (64'd1 << acc_value) : 64'd0;
                default:  res.error = 1'b1;
            endcase
        end
        parsed_results.push_back(res);
        acc_value   = '0;
        parse_state = PH_START;
        digit_seen  = 1'b0;
        unit_sel    = UNIT_NONE;
    endtask

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_cfg_we) begin
            int_mode = i_cfg_data;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            parse_char(i_char_code, i_default_unit);
        end
    end

    always @(negedge i_clk) begin
        if (!i_valid || in_fire) begin
            if (send_idle > 0) begin
                send_idle--;
                i_valid <= 1'b0;
            end else if (char_queue.size() > 0) begin
                send_item = char_queue.pop_front();
                i_valid <= 1'b1;
                i_char_code <= send_item.code;
                i_default_unit <= send_item.dflt;
                if (send_burst > 0) begin
                    send_burst--;
                    send_idle = 0;
                end else if ($urandom_range(0, 63) == 0) begin
                    send_burst = $urandom_range(20, 60);
                    send_idle = 0;
                end else begin
                    send_idle = $urandom_range(0, 1) ? 0 : gap_len();
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && char_queue.size() > 100) begin
            hold_done = 1'b1;
            hold_left = 400;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_stall <= 1'b1;
            stall_left = gap_len() - 1;
        end else begin
            i_stall <= 1'b0;
            stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 5);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (parsed_results.size() == 0) begin
                $error("result transfer with no string pending: value %h error %b",
                       o_parsed_value, o_error_flag);
                error_count++;
            end else begin
                if (o_parsed_value !== parsed_results[0].value) begin
                    $error("parsed_value: expected %h, got %h",
                           parsed_results[0].value, o_parsed_value);
                    error_count++;
                end
                if (o_error_flag !== parsed_results[0].error) begin
                    $error("error_flag: expected %b, got %b",
                           parsed_results[0].error, o_error_flag);
                    error_count++;
                end
                void'(parsed_results.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_decimal_size_with_unit_parser NOT OK");
            $finish;
        end
    end

    task automatic push_char(input logic [7:0] code, input logic [2:0] dflt);
        t_char_item it;
        it.code = code;
        it.dflt = dflt;
        char_queue.push_back(it);
        chars_pushed++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], 3'($urandom_range(0, 7)));
        end
    endtask

    task automatic push_string(input string s, input logic [2:0] dflt);
        push_text(s);
        push_char(CHAR_NUL, dflt);
    endtask

    task automatic gen_string();
        int n;
        int sfx;
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
                push_char(8'($urandom_range(1, 255)), 3'($urandom_range(0, 7)));
            end
        end else begin
            if ($urandom_range(0, 4) == 0) push_char(CHAR_EQ, 3'($urandom_range(0, 7)));
            sfx = $urandom_range(0, 9);
            r = $urandom_range(0, 99);
            if (sfx == 4) n = $urandom_range(1, 2);
            else if (r < 85) n = $urandom_range(1, 6);
            else if (r < 95) n = $urandom_range(7, 19);
            else n = $urandom_range(20, 22);
            for (int i = 0; i < n; i++) begin
                push_char(CHAR_0 + 8'($urandom_range(0, 9)), 3'($urandom_range(0, 7)));
            end
            if (sfx <= 4 || sfx >= 7) begin
                if (sfx <= 4) push_char(UNIT_CHARS[sfx], 3'($urandom_range(0, 7)));
                else if (sfx == 7) push_char(8'($urandom_range(1, 255)), 3'($urandom_range(0, 7)));
                else push_char(CHAR_EQ, 3'($urandom_range(0, 7)));
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    push_char(8'($urandom_range(1, 255)), 3'($urandom_range(0, 7)));
                end
            end
        end
        push_char(CHAR_NUL, 3'($urandom_range(0, 7)));
    endtask

    task automatic settle();
        while (char_queue.size() != 0 || i_valid || parsed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(MODE_SIZE);
        push_string("5k", UNIT_B);
        push_string("3m", UNIT_B);
        push_string("2g", UNIT_BAD);
        push_string("=7b", UNIT_NONE);
        push_string("63^", UNIT_B);
        push_string("64^", UNIT_B);
        push_char(CHAR_0 + 8'd1, 3'd0);
        push_char(8'hFF, 3'd7);
        push_char(CHAR_NUL, UNIT_B);
        push_string("=", UNIT_B);
        push_string("", UNIT_K);
        push_string("9", 3'd7);
        push_text("12");
        settle();

        // The open string is finished under the other mode.
        write_mode(MODE_INT);
        push_char(CHAR_NUL, UNIT_POW);
        push_string("8a", UNIT_B);
        push_string("", UNIT_B);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            write_mode((ph % 2 == 0) ? MODE_SIZE : MODE_INT);
            chars_pushed = 0;
            while (chars_pushed < PHASE_CHARS) gen_string();
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (error_count == 0 && parsed_results.size() == 0) begin
            $display("tb_decimal_size_with_unit_parser OK");
        end else begin
            $display("tb_decimal_size_with_unit_parser NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
src/dsu_pkg.sv
src/dsu_core.sv
src/decimal_size_with_unit_parser.sv
src/dsu_checker.sv
tb/tb_decimal_size_with_unit_parser.sv
